// File: sv/mixed_radix_index_decoder_macros.svh
// assertion macros for the mixed radix index decoder
`ifndef MIXED_RADIX_INDEX_DECODER_MACROS_SVH
`define MIXED_RADIX_INDEX_DECODER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define MRID_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define MRID_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mrid_pkg.sv
// shared types and codes for the mixed radix index decoder
package mrid_pkg;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_PLAN_INVALID = 3'd1,
    ST_OVERFLOW     = 3'd2,
    ST_SAVE_IN_IDX  = 3'd3,
    ST_INVALID_BYTE = 3'd4,
    ST_OPEN_AT_END  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_USE     = 2'd1,
    EV_SAVE    = 2'd2,
    EV_UNKNOWN = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    REG_TERM_RANGE = 3'd0,
    REG_CONT_RANGE = 3'd1,
    REG_MARKERS    = 3'd2,
    REG_TERM_RADIX = 3'd3,
    REG_CONT_RADIX = 3'd4,
    REG_TERM_BIAS  = 3'd5,
    REG_CONT_BIAS  = 3'd6
  } reg_idx_t;

  localparam logic        FUNC_FEED   = 1'b0;
  localparam logic        FUNC_FINISH = 1'b1;

  localparam logic [15:0] TERM_RANGE_RST = 16'h7F00;
  localparam logic [15:0] CONT_RANGE_RST = 16'hFD80;
  localparam logic [15:0] MARKERS_RST    = 16'hFFFE;
  localparam logic [31:0] TERM_RADIX_RST = 32'd128;
  localparam logic [31:0] CONT_RADIX_RST = 32'd128;
  localparam logic [31:0] TERM_BIAS_RST  = 32'd0;
  localparam logic [31:0] CONT_BIAS_RST  = 32'd0;

  typedef struct packed {
    logic [7:0]  term_lo;
    logic [7:0]  term_hi;
    logic [7:0]  cont_lo;
    logic [7:0]  cont_hi;
    logic [7:0]  save_mark;
    logic [7:0]  unk_mark;
    logic [31:0] term_radix;
    logic [31:0] cont_radix;
    logic [31:0] term_bias;
    logic [31:0] cont_bias;
    logic        plan_ok;
  } cfg_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    event_t      kind;
    logic [63:0] value;
  } result_t;

  typedef struct packed {
    logic [63:0] acc;
    logic        open;
  } state_t;

endpackage

// File: sv/mixed_radix_index_decoder.sv
// Mixed radix index decoder, top level. One result beat for every input beat.
// Throughput is one beat per clock while results are taken; an accepted beat
// goes into the input register and its result into the result register. The
// multiply-add of the accumulator (two 32x32 partial products and one 97-bit
// sum) sits between the input register and the result register and closes
// the accumulator loop, which fixes that rate. A stalled result lets one
// more beat into the input register and then drops in_ready until the
// result leaves. Any write to a mapped configuration register clears the
// accumulator and the open-index flag; there is no clearing pass after reset.
`include "mixed_radix_index_decoder_macros.svh"

module mixed_radix_index_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [1:0]  out_event_kind,
  output logic [63:0] out_index_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mrid_pkg::*;

  cfg_t     cfg;
  logic     cfg_clear;
  in_item_t s1_item_r;
  logic     s1_valid_r;
  result_t  out_res_r;
  logic     out_valid_r;
  state_t   st_r;
  state_t   st_nxt;
  result_t  res;
  logic     advance;

  mrid_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clear   (cfg_clear)
  );

  mrid_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (s1_item_r),
    .res    (res),
    .st_nxt (st_nxt)
  );

  // result register free, or its beat leaves this cycle
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_clear) begin
        st_r <= '0;
      end else if (s1_valid_r && advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.func      <= in_func;
      s1_item_r.data_byte <= in_data_byte;
    end
    if (s1_valid_r && advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_event_kind  = out_res_r.kind;
  assign out_index_value = out_res_r.value;

  `MRID_ASSERT_IMP(a_event_only_ok,
    out_valid_r && (out_res_r.kind != EV_NONE), out_res_r.status == ST_OK,
    "event with error status")
  `MRID_ASSERT_IMP(a_value_only_use,
    out_valid_r && (out_res_r.kind != EV_USE), out_res_r.value == 64'd0,
    "value without use event")
  `MRID_ASSERT_NXT(a_cfg_clears,
    cfg_clear, (st_r.acc == 64'd0) && !st_r.open,
    "config write did not clear state")
  `MRID_ASSERT_NXT(a_stage_held,
    s1_valid_r && !advance, s1_valid_r,
    "input stage beat dropped")

endmodule

// File: sv/mrid_cfg.sv
// configuration register file with plan check
module mrid_cfg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output mrid_pkg::cfg_t  cfg,
  output logic            clear
);
  import mrid_pkg::*;

  logic [15:0] term_range_r;
  logic [15:0] cont_range_r;
  logic [15:0] markers_r;
  logic [31:0] term_radix_r;
  logic [31:0] cont_radix_r;
  logic [31:0] term_bias_r;
  logic [31:0] cont_bias_r;
  logic        wr_en;
  logic [2:0]  idx;
  logic        idx_hit;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (idx)
      REG_TERM_RANGE: idx_hit = 1'b1;
      REG_CONT_RANGE: idx_hit = 1'b1;
      REG_MARKERS:    idx_hit = 1'b1;
      REG_TERM_RADIX: idx_hit = 1'b1;
      REG_CONT_RADIX: idx_hit = 1'b1;
      REG_TERM_BIAS:  idx_hit = 1'b1;
      REG_CONT_BIAS:  idx_hit = 1'b1;
      default:        idx_hit = 1'b0;
    endcase
  end

  // any write inside the map restarts decoding
  assign clear = wr_en && idx_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_range_r <= TERM_RANGE_RST;
      cont_range_r <= CONT_RANGE_RST;
      markers_r    <= MARKERS_RST;
      term_radix_r <= TERM_RADIX_RST;
      cont_radix_r <= CONT_RADIX_RST;
      term_bias_r  <= TERM_BIAS_RST;
      cont_bias_r  <= CONT_BIAS_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_TERM_RANGE: term_range_r <= pwdata[15:0];
        REG_CONT_RANGE: cont_range_r <= pwdata[15:0];
        REG_MARKERS:    markers_r    <= pwdata[15:0];
        REG_TERM_RADIX: term_radix_r <= pwdata;
        REG_CONT_RADIX: cont_radix_r <= pwdata;
        REG_TERM_BIAS:  term_bias_r  <= pwdata;
        REG_CONT_BIAS:  cont_bias_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TERM_RANGE: prdata = {16'd0, term_range_r};
      REG_CONT_RANGE: prdata = {16'd0, cont_range_r};
      REG_MARKERS:    prdata = {16'd0, markers_r};
      REG_TERM_RADIX: prdata = term_radix_r;
      REG_CONT_RADIX: prdata = cont_radix_r;
      REG_TERM_BIAS:  prdata = term_bias_r;
      REG_CONT_BIAS:  prdata = cont_bias_r;
      default:        prdata = 32'd0;
    endcase
  end

  logic ranges_ok;
  logic disjoint;
  logic save_clear;
  logic unk_clear;

  always_comb begin
    cfg.term_lo    = term_range_r[7:0];
    cfg.term_hi    = term_range_r[15:8];
    cfg.cont_lo    = cont_range_r[7:0];
    cfg.cont_hi    = cont_range_r[15:8];
    cfg.save_mark  = markers_r[7:0];
    cfg.unk_mark   = markers_r[15:8];
    cfg.term_radix = term_radix_r;
    cfg.cont_radix = cont_radix_r;
    cfg.term_bias  = term_bias_r;
    cfg.cont_bias  = cont_bias_r;

    ranges_ok  = (cfg.term_lo <= cfg.term_hi) && (cfg.cont_lo <= cfg.cont_hi);
    disjoint   = (cfg.term_hi < cfg.cont_lo) || (cfg.cont_hi < cfg.term_lo);
    save_clear = !((cfg.save_mark >= cfg.term_lo) && (cfg.save_mark <= cfg.term_hi)) &&
                 !((cfg.save_mark >= cfg.cont_lo) && (cfg.save_mark <= cfg.cont_hi));
    unk_clear  = !((cfg.unk_mark >= cfg.term_lo) && (cfg.unk_mark <= cfg.term_hi)) &&
                 !((cfg.unk_mark >= cfg.cont_lo) && (cfg.unk_mark <= cfg.cont_hi));
    cfg.plan_ok = ranges_ok && disjoint && save_clear && unk_clear &&
                  (cfg.save_mark != cfg.unk_mark) &&
                  (term_radix_r != 32'd0) && (cont_radix_r != 32'd0);
  end

endmodule

// File: sv/mrid_step.sv
// byte classification and multiply-add for one beat
module mrid_step (
  input  mrid_pkg::cfg_t     cfg,
  input  mrid_pkg::state_t   st,
  input  mrid_pkg::in_item_t item,
  output mrid_pkg::result_t  res,
  output mrid_pkg::state_t   st_nxt
);
  import mrid_pkg::*;

  logic        in_term;
  logic        in_cont;
  logic [7:0]  diff;
  logic [31:0] radix;
  logic [31:0] bias;
  logic [32:0] digit;
  logic [63:0] plo;
  logic [63:0] phi;
  logic [96:0] total;
  logic        ovf;

  assign in_term = (item.data_byte >= cfg.term_lo) && (item.data_byte <= cfg.term_hi);
  assign in_cont = (item.data_byte >= cfg.cont_lo) && (item.data_byte <= cfg.cont_hi);

  // terminal range wins the operand select, as in the decode order
  assign diff  = in_term ? (item.data_byte - cfg.term_lo) : (item.data_byte - cfg.cont_lo);
  assign radix = in_term ? cfg.term_radix : cfg.cont_radix;
  assign bias  = in_term ? cfg.term_bias : cfg.cont_bias;
  assign digit = {25'd0, diff} + {1'b0, bias};

  // 64x32 product as two 32x32 halves, exact to 97 bits
  assign plo   = {32'd0, st.acc[31:0]} * {32'd0, radix};
  assign phi   = {32'd0, st.acc[63:32]} * {32'd0, radix};
  assign total = {1'b0, phi, 32'd0} + {33'd0, plo} + {64'd0, digit};
  assign ovf   = |total[96:64];

  always_comb begin
    res.status = ST_OK;
    res.kind   = EV_NONE;
    res.value  = 64'd0;
    st_nxt     = st;
    priority if (!cfg.plan_ok) begin
      res.status = ST_PLAN_INVALID;
    end else if (item.func == FUNC_FINISH) begin
      res.status = st.open ? ST_OPEN_AT_END : ST_OK;
    end else if (in_term) begin
      if (ovf) begin
        res.status = ST_OVERFLOW;
      end else begin
        res.kind    = EV_USE;
        res.value   = total[63:0];
        st_nxt.acc  = 64'd0;
        st_nxt.open = 1'b0;
      end
    end else if (in_cont) begin
      if (ovf) begin
        res.status = ST_OVERFLOW;
      end else begin
        st_nxt.acc  = total[63:0];
        st_nxt.open = 1'b1;
      end
    end else if (item.data_byte == cfg.save_mark) begin
      if (st.open) begin
        res.status = ST_SAVE_IN_IDX;
      end else begin
        res.kind = EV_SAVE;
      end
    end else if (item.data_byte == cfg.unk_mark) begin
      res.kind    = EV_UNKNOWN;
      st_nxt.acc  = 64'd0;
      st_nxt.open = 1'b0;
    end else begin
      res.status = ST_INVALID_BYTE;
    end
  end

endmodule

// File: verif/mrid_result_check.sv
// result checker for the mixed radix index decoder: tracks the plan, predicts and compares
module mrid_result_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [1:0]  out_event_kind,
  input  logic [63:0] out_index_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mrid_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic [15:0] term_rng, cont_rng, marks;
  logic [31:0] term_rad, cont_rad, term_bias, cont_bias;
  logic [63:0] acc;
  logic        idx_open;

  result_t expected_results[$];

  function automatic logic covers(input logic [7:0] lo, input logic [7:0] hi,
                                  input logic [7:0] b);
    return b >= lo && b <= hi;
  endfunction

  function automatic logic plan_valid();
    logic [7:0] tl, th, cl, ch, sv, uk;
    {th, tl} = term_rng;
    {ch, cl} = cont_rng;
    {uk, sv} = marks;
    if (tl > th || cl > ch) return 1'b0;
    if (!(th < cl || ch < tl)) return 1'b0;
    if (covers(tl, th, sv) || covers(cl, ch, sv)) return 1'b0;
    if (covers(tl, th, uk) || covers(cl, ch, uk)) return 1'b0;
    if (sv == uk) return 1'b0;
    return term_rad != '0 && cont_rad != '0;
  endfunction

  // exact radix*acc + digit; false when anything lands above bit 63
  function automatic logic mul_add(input logic [31:0] radix, input logic [63:0] a,
                                   input logic [32:0] digit, output logic [63:0] sum);
    logic [96:0] wide;
    wide = {65'd0, radix} * {33'd0, a} + {64'd0, digit};
    sum = wide[63:0];
    return wide[96:64] == '0;
  endfunction

  function automatic result_t decode_step(input logic f, input logic [7:0] b);
    result_t     r;
    logic [7:0]  tl, th, cl, ch, sv, uk;
    logic [32:0] digit;
    logic [63:0] nv;
    {th, tl} = term_rng;
    {ch, cl} = cont_rng;
    {uk, sv} = marks;
    r.status = ST_OK;
    r.kind = EV_NONE;
    r.value = '0;
    if (!plan_valid()) begin
      r.status = ST_PLAN_INVALID;
    end else if (f == FUNC_FINISH) begin
      r.status = idx_open ? ST_OPEN_AT_END : ST_OK;
    end else if (covers(tl, th, b)) begin
      digit = {25'd0, 8'(b - tl)} + {1'b0, term_bias};
      if (!mul_add(term_rad, acc, digit, nv)) begin
        r.status = ST_OVERFLOW;
      end else begin
        acc = '0;
        idx_open = 1'b0;
        r.kind = EV_USE;
        r.value = nv;
      end
    end else if (covers(cl, ch, b)) begin
      digit = {25'd0, 8'(b - cl)} + {1'b0, cont_bias};
      if (!mul_add(cont_rad, acc, digit, nv)) begin
        r.status = ST_OVERFLOW;
      end else begin
        acc = nv;
        idx_open = 1'b1;
      end
    end else if (b == sv) begin
      if (idx_open) r.status = ST_SAVE_IN_IDX;
      else r.kind = EV_SAVE;
    end else if (b == uk) begin
      acc = '0;
      idx_open = 1'b0;
      r.kind = EV_UNKNOWN;
    end else begin
      r.status = ST_INVALID_BYTE;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    errors++;
    if (errors <= REPORT_LIMIT)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : track
    result_t want;
    if (!rst_n) begin
      term_rng = TERM_RANGE_RST;
      cont_rng = CONT_RANGE_RST;
      marks = MARKERS_RST;
      term_rad = TERM_RADIX_RST;
      cont_rad = CONT_RADIX_RST;
      term_bias = TERM_BIAS_RST;
      cont_bias = CONT_BIAS_RST;
      acc = '0;
      idx_open = 1'b0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        // a write to a mapped register restarts decoding
        case (paddr[4:2])
          REG_TERM_RANGE: term_rng = pwdata[15:0];
          REG_CONT_RANGE: cont_rng = pwdata[15:0];
          REG_MARKERS:    marks = pwdata[15:0];
          REG_TERM_RADIX: term_rad = pwdata;
          REG_CONT_RADIX: cont_rad = pwdata;
          REG_TERM_BIAS:  term_bias = pwdata;
          REG_CONT_BIAS:  cont_bias = pwdata;
          default: ;
        endcase
        if (paddr[4:2] <= REG_CONT_BIAS) begin
          acc = '0;
          idx_open = 1'b0;
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(decode_step(in_func, in_data_byte));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result beat, status", 64'(out_status), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            note_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_event_kind !== want.kind)
            note_mismatch("event", 64'(out_event_kind), 64'(want.kind));
          if (out_index_value !== want.value)
            note_mismatch("index value", out_index_value, want.value);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: verif/mixed_radix_index_decoder_test.sv
// testbench top for the mixed radix index decoder: clock, reset, stimulus and verdict
module mixed_radix_index_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mrid_pkg::*;

  localparam int         TARGET_ITEMS   = 900;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         MAX_WAIT       = 17;
  localparam logic [4:0] UNMAPPED_ADDR  = 5'd28;

  typedef struct packed {
    logic [15:0] term_rng;
    logic [15:0] cont_rng;
    logic [15:0] marks;
    logic [31:0] term_rad;
    logic [31:0] cont_rad;
    logic [31:0] term_bias;
    logic [31:0] cont_bias;
  } plan_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [1:0]  out_event_kind;
  logic [63:0] out_index_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int    errors;
  int    pending;
  int    items_sent;
  logic  steady;
  plan_t plan;

  mixed_radix_index_decoder dut (.*);

  mrid_result_check result_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic plan_t reset_plan();
    plan_t p;
    p.term_rng = TERM_RANGE_RST;
    p.cont_rng = CONT_RANGE_RST;
    p.marks = MARKERS_RST;
    p.term_rad = TERM_RADIX_RST;
    p.cont_rad = CONT_RADIX_RST;
    p.term_bias = TERM_BIAS_RST;
    p.cont_bias = CONT_BIAS_RST;
    return p;
  endfunction

  function automatic plan_t broken_plan(input int sel);
    plan_t p;
    p = reset_plan();
    case (sel)
      0: p.term_rng = 16'h0010;     // terminal low above high
      1: p.cont_rng = 16'h80FD;     // continuation low above high
      2: p.cont_rng = 16'hFD70;     // ranges overlap
      3: p.marks = 16'hFF10;        // save marker inside a range
      4: p.marks = 16'h10FE;        // unknown marker inside a range
      5: p.marks = 16'hFEFE;        // markers equal
      6: p.term_rad = '0;
      default: p.cont_rad = '0;
    endcase
    return p;
  endfunction

  function automatic logic [31:0] pick_radix();
    case ($urandom_range(7, 0))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(256, 2);
    endcase
  endfunction

  function automatic logic [31:0] pick_bias();
    case ($urandom_range(7, 0))
      0, 1: return '0;
      2: return 32'hFFFF_FFFF;
      3: return $urandom;
      default: return $urandom_range(255, 0);
    endcase
  endfunction

  function automatic logic [7:0] spare_byte(input int i);
    return (i < 2) ? 8'(i) : 8'(252 + i);
  endfunction

  // two disjoint ranges inside 2..253, markers taken from the four outer bytes
  function automatic plan_t random_plan();
    plan_t      p;
    logic [7:0] lo_a, hi_a, lo_b, hi_b;
    int         s, u;
    lo_a = 8'($urandom_range(120, 2));
    hi_a = 8'($urandom_range(126, lo_a));
    lo_b = 8'($urandom_range(253, 127));
    hi_b = 8'($urandom_range(253, lo_b));
    if ($urandom_range(1, 0) == 1) begin
      p.term_rng = {hi_a, lo_a};
      p.cont_rng = {hi_b, lo_b};
    end else begin
      p.term_rng = {hi_b, lo_b};
      p.cont_rng = {hi_a, lo_a};
    end
    s = $urandom_range(3, 0);
    u = (s + $urandom_range(3, 1)) % 4;
    p.marks = {spare_byte(u), spare_byte(s)};
    p.term_rad = pick_radix();
    p.cont_rad = pick_radix();
    p.term_bias = pick_bias();
    p.cont_bias = pick_bias();
    return p;
  endfunction

  function automatic logic [7:0] pick(input logic [15:0] rng);
    return 8'($urandom_range(rng[15:8], rng[7:0]));
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic push_item(input logic f, input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(MAX_WAIT, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_data_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic feed(input logic [7:0] b);
    push_item(FUNC_FEED, b);
  endtask

  // wait for every result, then let the pipe settle
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [4:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!(psel && penable && pwrite && pready));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_plan(input plan_t p);
    settle();
    cfg_write({REG_TERM_RANGE, 2'b00}, {16'd0, p.term_rng});
    cfg_write({REG_CONT_RANGE, 2'b00}, {16'd0, p.cont_rng});
    cfg_write({REG_MARKERS, 2'b00}, {16'd0, p.marks});
    cfg_write({REG_TERM_RADIX, 2'b00}, p.term_rad);
    cfg_write({REG_CONT_RADIX, 2'b00}, p.cont_rad);
    cfg_write({REG_TERM_BIAS, 2'b00}, p.term_bias);
    cfg_write({REG_CONT_BIAS, 2'b00}, p.cont_bias);
    plan = p;
  endtask

  task automatic send_number(input int digits);
    repeat (digits) feed(pick(plan.cont_rng));
    feed(pick(plan.term_rng));
  endtask

  task automatic run_phase(input int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      case ($urandom_range(19, 0))
        0, 1, 2, 3, 4, 5, 6, 7, 8: send_number($urandom_range(3, 0));
        9: send_number($urandom_range(12, 4));
        10, 11: feed(plan.marks[7:0]);
        12: feed(plan.marks[15:8]);
        13: push_item(FUNC_FINISH, 8'($urandom));
        14: feed(8'($urandom));
        15: begin
          // save arriving inside an open index
          feed(pick(plan.cont_rng));
          feed(plan.marks[7:0]);
        end
        16: begin
          // index left open at finish, then abandoned
          feed(pick(plan.cont_rng));
          push_item(FUNC_FINISH, 8'($urandom));
          feed(plan.marks[15:8]);
        end
        17: feed(pick(plan.cont_rng));
        default: push_item(1'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = steady ? 0 : $urandom_range(MAX_WAIT, 0);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("mixed_radix_index_decoder_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    plan_t p;
    int    sel;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_FEED;
    in_data_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    items_sent = 0;
    plan = reset_plan();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset plan: terminal extremes, low continuation end, markers, open index cases
    push_item(FUNC_FINISH, 8'hFF);
    feed(8'h00);
    feed(8'h7F);
    feed(8'hFE);
    feed(8'hFF);
    feed(8'h80);
    push_item(FUNC_FINISH, 8'h00);
    feed(8'hFE);
    // a write off the register map must not drop the open index
    settle();
    cfg_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    push_item(FUNC_FINISH, 8'h55);
    feed(8'h01);

    // gaps around the ranges, overflow from the widest radix and bias
    p.term_rng = 16'h1F10;
    p.cont_rng = 16'h2F20;
    p.marks = 16'h3130;
    p.term_rad = 32'hFFFF_FFFF;
    p.cont_rad = 32'hFFFF_FFFF;
    p.term_bias = 32'hFFFF_FFFF;
    p.cont_bias = 32'hFFFF_FFFF;
    load_plan(p);
    feed(8'h00);
    feed(8'hFF);
    feed(8'h2F);
    feed(8'h2F);
    feed(8'h1F);
    feed(8'h31);
    feed(8'h30);
    feed(8'h10);

    for (int i = 0; i < 8; i++) begin
      load_plan(broken_plan(i));
      push_item(i[0] ? FUNC_FINISH : FUNC_FEED, 8'($urandom));
    end

    while (items_sent < TARGET_ITEMS) begin
      sel = $urandom_range(11, 0);
      case (sel)
        0: p = reset_plan();
        1: begin
          p.term_rng = 16'h0000;
          p.cont_rng = 16'hFF03;
          p.marks = 16'h0201;
          p.term_rad = 32'd1;
          p.cont_rad = 32'd1;
          p.term_bias = '0;
          p.cont_bias = 32'hFFFF_FFFF;
        end
        2: begin
          p.term_rng = 16'hFFFF;
          p.cont_rng = 16'hFC00;
          p.marks = 16'hFEFD;
          p.term_rad = 32'hFFFF_FFFF;
          p.cont_rad = 32'd2;
          p.term_bias = 32'hFFFF_FFFF;
          p.cont_bias = '0;
        end
        3: p = broken_plan($urandom_range(7, 0));
        default: p = random_plan();
      endcase
      load_plan(p);
      steady = ($urandom_range(3, 0) == 0);
      run_phase(sel == 3 ? 5 : $urandom_range(80, 30));
      steady = 1'b0;
    end

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("mixed_radix_index_decoder_test: PASS");
    else
      $display("mixed_radix_index_decoder_test: FAIL");
    $finish;
  end

endmodule
